// ----- src/nfa_tt_pkg.sv -----
// ----------------------------------------------------------------------------
// nfa_tt_pkg
// Shared types and codes for the NFA transition table block: controller
// states, item operations, symbol kinds and the packed transition entry.
// ----------------------------------------------------------------------------
package nfa_tt_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD_STATE,
        OP_REMOVE_STATE,
        OP_ADD_TRANS,
        OP_STEP
    } op_t;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_ANY     = 2'd2;
    localparam logic [1:0] KIND_RSVD    = 2'd3;

    localparam int KIND_W  = 2;
    localparam int SYM_W   = 8;
    localparam int DEST_W  = 6;
    localparam int ENTRY_W = KIND_W + SYM_W + DEST_W;
    localparam int SET_W   = 64;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
        logic [DEST_W-1:0] dest;
    } entry_t;

endpackage

// ----- src/nfa_tt_in_if.sv -----
// ----------------------------------------------------------------------------
// nfa_tt_in_if
// Input item channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface nfa_tt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  from_state;
    logic [5:0]  to_state;
    logic [7:0]  symbol;
    logic [1:0]  symbol_kind;
    logic [63:0] origin_set;

    modport source (
        output valid, operation, from_state, to_state, symbol, symbol_kind, origin_set,
        input  ready
    );
    modport sink (
        input  valid, operation, from_state, to_state, symbol, symbol_kind, origin_set,
        output ready
    );
endinterface

// ----- src/nfa_tt_out_if.sv -----
// ----------------------------------------------------------------------------
// nfa_tt_out_if
// Result channel: valid/ready handshake with the step result payload.
// ----------------------------------------------------------------------------
interface nfa_tt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_set;
    logic        error;
    logic [6:0]  state_count;

    modport source (
        output valid, next_set, error, state_count,
        input  ready
    );
    modport sink (
        input  valid, next_set, error, state_count,
        output ready
    );
endinterface

// ----- src/nfa_tt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// nfa_tt_cfg_if
// Configuration write channel: valid/ready handshake with the register data.
// ----------------------------------------------------------------------------
interface nfa_tt_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ----- src/nfa_tt_ram.sv -----
// ----------------------------------------------------------------------------
// nfa_tt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nfa_tt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/nfa_transition_table_step.sv -----
// ----------------------------------------------------------------------------
// nfa_transition_table_step
// NFA transition table with a one-symbol step over a set of states. Each
// state owns one RAM row holding its entries and its entry count.
// Add transition reads the source row, then writes it back with the new
// entry; step reads one row per defined state.
// One item is in work at a time; the next is taken once the result is in the
// output register, which holds it until the sink takes it.
// Reset clears the state count and the per-row valid bits (rows read as
// empty), and sets any_enable to 1. No RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module nfa_transition_table_step #(
    parameter int MAX_STATES        = 64,
    parameter int ENTRIES_PER_STATE = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    nfa_tt_in_if.sink            item,
    nfa_tt_out_if.source         result,
    nfa_tt_cfg_if.sink           cfg
);

    localparam int SW     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int CNTW   = $clog2(MAX_STATES + 1);
    localparam int EW     = $clog2(ENTRIES_PER_STATE + 1);
    localparam int ROW_W  = ENTRIES_PER_STATE * nfa_tt_pkg::ENTRY_W + EW;
    localparam int CNT_LSB = ENTRIES_PER_STATE * nfa_tt_pkg::ENTRY_W;

    nfa_tt_pkg::state_t state_reg, state_next;

    logic [CNTW-1:0]       count_reg, count_next;
    logic [MAX_STATES-1:0] valid_reg, valid_next;
    logic [CNTW-1:0]       scan_reg, scan_next;
    logic                  pend_reg, pend_next;
    logic [nfa_tt_pkg::SET_W-1:0] acc_reg, acc_next;
    logic                  err_reg, err_next;
    logic                  any_en_reg;

    logic [5:0]            from_reg, to_reg;
    logic [7:0]            sym_reg;
    logic [1:0]            kind_reg;
    logic [63:0]           origin_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [nfa_tt_pkg::SET_W-1:0]   out_set_reg;
    logic                  out_err_reg;
    logic [nfa_tt_pkg::COUNT_W-1:0] out_cnt_reg;
    logic                  out_load;

    logic                  item_xfer;
    logic                  ram_wr_en, ram_rd_en;
    logic [SW-1:0]         ram_wr_addr, ram_rd_addr;
    logic [ROW_W-1:0]      ram_wr_data, ram_rd_data;

    logic [nfa_tt_pkg::COUNT_W-1:0] count7;
    logic [MAX_STATES-1:0] origin_used;
    logic [SW-1:0]         from_idx, scan_idx, last_idx;
    logic [EW-1:0]         rd_cnt, cnt_eff;
    logic [nfa_tt_pkg::SET_W-1:0] match_mask;
    logic [ROW_W-1:0]      row_new;
    nfa_tt_pkg::entry_t    new_entry;

    function automatic logic entry_hit(
        input nfa_tt_pkg::entry_t e,
        input logic [1:0]         k,
        input logic [7:0]         s,
        input logic               any_en
    );
        logic hit;
        hit = (e.kind == k) && ((k != nfa_tt_pkg::KIND_LITERAL) || (e.sym == s));
        return hit || (any_en && (e.kind == nfa_tt_pkg::KIND_ANY));
    endfunction

    nfa_tt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_STATES)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign count7      = nfa_tt_pkg::COUNT_W'(count_reg);
    assign origin_used = origin_reg[MAX_STATES-1:0];
    assign from_idx    = from_reg[SW-1:0];
    assign scan_idx    = scan_reg[SW-1:0];
    assign last_idx    = SW'(count_reg - 1'b1);
    assign rd_cnt      = ram_rd_data[CNT_LSB +: EW];
    assign cnt_eff     = valid_reg[from_idx] ? rd_cnt : '0;

    assign item.ready  = (state_reg == nfa_tt_pkg::ST_IDLE);
    assign item_xfer   = item.valid && item.ready;
    assign cfg.ready   = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.next_set    = out_set_reg;
    assign result.error       = out_err_reg;
    assign result.state_count = out_cnt_reg;

    // Match all entries of the returned row in parallel.
    always_comb
    begin
        nfa_tt_pkg::entry_t e;
        match_mask = '0;
        for (int i = 0; i < ENTRIES_PER_STATE; i++)
        begin
            e = nfa_tt_pkg::entry_t'(ram_rd_data[i*nfa_tt_pkg::ENTRY_W +: nfa_tt_pkg::ENTRY_W]);
            if ((EW'(i) < rd_cnt) && entry_hit(e, kind_reg, sym_reg, any_en_reg))
            begin
                match_mask[e.dest] = 1'b1;
            end
        end
    end

    // Insert the new entry at the first free slot of the row.
    always_comb
    begin
        new_entry.kind = kind_reg;
        new_entry.sym  = (kind_reg == nfa_tt_pkg::KIND_LITERAL) ? sym_reg : '0;
        new_entry.dest = to_reg;
        row_new = ram_rd_data;
        for (int i = 0; i < ENTRIES_PER_STATE; i++)
        begin
            if (cnt_eff == EW'(i))
            begin
                row_new[i*nfa_tt_pkg::ENTRY_W +: nfa_tt_pkg::ENTRY_W] = new_entry;
            end
        end
        row_new[CNT_LSB +: EW] = cnt_eff + 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        acc_next       = acc_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_load       = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = from_idx;
        ram_wr_data    = row_new;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = from_idx;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            nfa_tt_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    acc_next = '0;
                    err_next = 1'b0;
                    state_next = nfa_tt_pkg::ST_DONE;
                    unique case (nfa_tt_pkg::op_t'(item.operation))
                        nfa_tt_pkg::OP_ADD_STATE:
                        begin
                            if (count_reg >= CNTW'(MAX_STATES))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        nfa_tt_pkg::OP_REMOVE_STATE:
                        begin
                            if (count_reg == '0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                valid_next[last_idx] = 1'b0;
                            end
                        end
                        nfa_tt_pkg::OP_ADD_TRANS:
                        begin
                            if (({1'b0, item.from_state} >= count7)
                                || ({1'b0, item.to_state} >= count7)
                                || (item.symbol_kind == nfa_tt_pkg::KIND_RSVD)
                                || ((item.symbol_kind == nfa_tt_pkg::KIND_ANY) && !any_en_reg))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                state_next = nfa_tt_pkg::ST_ADD_RD;
                            end
                        end
                        nfa_tt_pkg::OP_STEP:
                        begin
                            if (item.symbol_kind == nfa_tt_pkg::KIND_RSVD)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = nfa_tt_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            err_next = 1'b1;
                        end
                    endcase
                end
            end
            nfa_tt_pkg::ST_ADD_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = nfa_tt_pkg::ST_ADD_WR;
            end
            nfa_tt_pkg::ST_ADD_WR:
            begin
                if (cnt_eff >= EW'(ENTRIES_PER_STATE))
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    ram_wr_en = 1'b1;
                    valid_next[from_idx] = 1'b1;
                end
                state_next = nfa_tt_pkg::ST_DONE;
            end
            nfa_tt_pkg::ST_SCAN:
            begin
                if (pend_reg)
                begin
                    acc_next = acc_reg | match_mask;
                end
                if (scan_reg < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = scan_idx;
                    pend_next   = origin_used[scan_idx] && valid_reg[scan_idx];
                    scan_next   = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = nfa_tt_pkg::ST_DONE;
                end
            end
            nfa_tt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = nfa_tt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfa_tt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfa_tt_pkg::ST_IDLE;
            count_reg     <= '0;
            valid_reg     <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            any_en_reg    <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                any_en_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        err_reg <= err_next;
        if (item_xfer)
        begin
            from_reg   <= item.from_state;
            to_reg     <= item.to_state;
            sym_reg    <= item.symbol;
            kind_reg   <= item.symbol_kind;
            origin_reg <= item.origin_set;
        end
        if (out_load)
        begin
            out_set_reg <= acc_reg;
            out_err_reg <= err_reg;
            out_cnt_reg <= count7;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_STATES))
        else $error("state count above capacity");

    a_rows_above_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg >> count_reg) == '0)
        else $error("row valid above state count");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> !item.ready)
        else $error("second item taken while one is in work");

    a_error_empty_set: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.error) |-> (result.next_set == '0))
        else $error("rejected item carries a destination set");

    a_pend_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == nfa_tt_pkg::ST_SCAN && $past(ram_rd_en)))
        else $error("row match pending outside a scan");

endmodule
